@@ rtl/ukls_pkg.sv @@
// shared types and constants for the unique-key lifo stack
package ukls_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CNT_OUT_W   = 5;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 136;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_POP,
        S_RESP
    } t_state;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

endpackage

@@ rtl/ukls_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module ukls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/unique_key_lifo_stack_top.sv @@
// top level of the unique-key lifo stack: sequencer, top-of-stack registers and result stage
// A push walks the stored keys one per cycle through a single key comparator reading the
// entry ram, so the block is not ready again until the walk is over; a duplicate hit ends
// the walk early. A pop that leaves entries behind reads the entry that becomes the new top
// from the ram. One transaction is worked on at a time; a finished result sits in the
// output register while the next transaction is taken.
module unique_key_lifo_stack_top #(
    parameter int DEPTH = ukls_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // push_key [31:0], push_data [63:32]
    input  logic [ukls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status [1:0], popped_key [33:2], popped_data [65:34], top_key [97:66],
    // top_data [129:98], entry_count [134:130], is_empty [135]
    output logic [ukls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW = ukls_pkg::KEY_W;
    localparam int DW = ukls_pkg::DATA_W;

    ukls_pkg::t_state  r_state, n_state;
    ukls_pkg::t_status r_status, n_status;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [KW-1:0]     r_key, n_key;
    logic [DW-1:0]     r_data, n_data;
    logic [KW-1:0]     r_top_key, n_top_key;
    logic [DW-1:0]     r_top_data, n_top_data;
    logic [KW-1:0]     r_pop_key, n_pop_key;
    logic [DW-1:0]     r_pop_data, n_pop_data;
    logic              r_out_valid, n_out_valid;
    logic [ukls_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [KW+DW-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [KW+DW-1:0]  ram_rdata;
    logic              in_fire;
    ukls_pkg::t_op     in_op;

    ukls_ram #(
        .WIDTH (KW + DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ukls_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_op         = ukls_pkg::t_op'(s_axis_tuser);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ukls_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_top_key   <= '0;
            r_top_data  <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_top_key   <= n_top_key;
            r_top_data  <= n_top_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_idx      <= n_idx;
        r_pend     <= n_pend;
        r_key      <= n_key;
        r_data     <= n_data;
        r_pop_key  <= n_pop_key;
        r_pop_data <= n_pop_data;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_key       = r_key;
        n_data      = r_data;
        n_top_key   = r_top_key;
        n_top_data  = r_top_data;
        n_pop_key   = r_pop_key;
        n_pop_data  = r_pop_data;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = {r_data, r_key};
        ram_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            ukls_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_key      = s_axis_tdata[KW-1:0];
                    n_data     = s_axis_tdata[KW+DW-1:KW];
                    n_pop_key  = '0;
                    n_pop_data = '0;
                    n_status   = ukls_pkg::ST_DONE;
                    unique case (in_op)
                        ukls_pkg::OP_PUSH: begin
                            if (r_count == '0) begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = s_axis_tdata[KW+DW-1:0];
                                n_top_key  = s_axis_tdata[KW-1:0];
                                n_top_data = s_axis_tdata[KW+DW-1:KW];
                                n_count    = CW'(1);
                                n_state    = ukls_pkg::S_RESP;
                            end else begin
                                n_idx   = '0;
                                n_pend  = 1'b0;
                                n_state = ukls_pkg::S_SEARCH;
                            end
                        end
                        ukls_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ukls_pkg::ST_EMPTY;
                                n_state  = ukls_pkg::S_RESP;
                            end else begin
                                n_pop_key  = r_top_key;
                                n_pop_data = r_top_data;
                                n_count    = r_count - CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_top_key  = '0;
                                    n_top_data = '0;
                                    n_state    = ukls_pkg::S_RESP;
                                end else begin
                                    ram_raddr = AW'(r_count - CW'(2));
                                    n_state   = ukls_pkg::S_POP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ukls_pkg::S_SEARCH: begin
                if (r_pend && (ram_rdata[KW-1:0] == r_key)) begin
                    n_status = ukls_pkg::ST_DUP;
                    n_state  = ukls_pkg::S_RESP;
                end else if (r_idx == r_count) begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ukls_pkg::ST_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        n_top_key  = r_key;
                        n_top_data = r_data;
                        n_count    = r_count + CW'(1);
                    end
                    n_state = ukls_pkg::S_RESP;
                end else begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end
            end
            ukls_pkg::S_POP: begin
                n_top_key  = ram_rdata[KW-1:0];
                n_top_data = ram_rdata[KW+DW-1:KW];
                n_state    = ukls_pkg::S_RESP;
            end
            ukls_pkg::S_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {(r_count == '0),
                                   ukls_pkg::CNT_OUT_W'(r_count),
                                   r_top_data,
                                   r_top_key,
                                   r_pop_data,
                                   r_pop_key,
                                   r_status};
                    n_state     = ukls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ukls_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ test/ukls_checker.sv @@
// checker for the unique-key lifo stack: stack predictor, expected-result queue and comparison
module ukls_checker #(
    parameter int DEPTH = ukls_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // push_key [31:0], push_data [63:32]
    input  logic [ukls_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // mode [0]
    input  logic                             i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // status [1:0], popped_key [33:2], popped_data [65:34], top_key [97:66],
    // top_data [129:98], entry_count [134:130], is_empty [135]
    input  logic [ukls_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // laid out to match the result tdata bit for bit
    typedef struct packed {
        logic                           is_empty;
        logic [ukls_pkg::CNT_OUT_W-1:0] entry_count;
        logic [ukls_pkg::DATA_W-1:0]    top_data;
        logic [ukls_pkg::KEY_W-1:0]     top_key;
        logic [ukls_pkg::DATA_W-1:0]    popped_data;
        logic [ukls_pkg::KEY_W-1:0]     popped_key;
        ukls_pkg::t_status              status;
    } t_stack_result;

    logic [ukls_pkg::KEY_W-1:0]  key_mem [DEPTH];
    logic [ukls_pkg::DATA_W-1:0] data_mem [DEPTH];
    int                          held;
    t_stack_result               expected_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held         = 0;
    end

    function automatic t_stack_result apply_op(ukls_pkg::t_op op,
                                               logic [ukls_pkg::KEY_W-1:0] key,
                                               logic [ukls_pkg::DATA_W-1:0] data);
        t_stack_result r;
        bit            hit;
        r        = '0;
        r.status = ukls_pkg::ST_DONE;
        hit      = 1'b0;
        if (op == ukls_pkg::OP_PUSH) begin
            for (int i = 0; i < held; i++) begin
                if (key_mem[i] == key) hit = 1'b1;
            end
            if (hit) begin
                r.status = ukls_pkg::ST_DUP;
            end else if (held >= DEPTH) begin
                r.status = ukls_pkg::ST_FULL;
            end else begin
                key_mem[held]  = key;
                data_mem[held] = data;
                held++;
            end
        end else if (held == 0) begin
            r.status = ukls_pkg::ST_EMPTY;
        end else begin
            held--;
            r.popped_key  = key_mem[held];
            r.popped_data = data_mem[held];
        end
        if (held > 0) begin
            r.top_key  = key_mem[held-1];
            r.top_data = data_mem[held-1];
        end
        r.entry_count = ukls_pkg::CNT_OUT_W'(held);
        r.is_empty    = (held == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_result exp_r;
        t_stack_result got_r;
        if (!i_rst_n) begin
            expected_q.delete();
            held = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(apply_op(ukls_pkg::t_op'(i_s_tuser),
                                              i_s_tdata[31:0], i_s_tdata[63:32]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got_r = t_stack_result'(i_m_tdata);
                if (expected_q.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    o_fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(got_r.status));
                    check_field("popped_key", exp_r.popped_key, got_r.popped_key);
                    check_field("popped_data", exp_r.popped_data, got_r.popped_data);
                    check_field("top_key", exp_r.top_key, got_r.top_key);
                    check_field("top_data", exp_r.top_data, got_r.top_data);
                    check_field("entry_count", 32'(exp_r.entry_count),
                                32'(got_r.entry_count));
                    check_field("is_empty", 32'(exp_r.is_empty), 32'(got_r.is_empty));
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

@@ test/tb_unique_key_lifo_stack_top.sv @@
// testbench top for the unique-key lifo stack: clock, reset, push/pop traffic and verdict
module tb_unique_key_lifo_stack_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = ukls_pkg::DEPTH_DEF;
    localparam int NUM_PHASES  = 15;
    localparam int PHASE_ITEMS = 40;
    localparam int POOL_SIZE   = 24;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ukls_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             s_axis_tuser  = ukls_pkg::OP_PUSH;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ukls_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int                               fail_count;
    int                               pending;
    bit                               calm          = 1'b0;
    int                               stall_left    = 0;
    logic [ukls_pkg::KEY_W-1:0]       key_pool [POOL_SIZE];
    int                               push_pct [5]  = '{90, 30, 70, 10, 50};

    unique_key_lifo_stack_top #(
        .DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ukls_checker #(
        .DEPTH (STACK_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [ukls_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, POOL_SIZE-1)];
        return $urandom();
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left    <= idle_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input ukls_pkg::t_op op, input logic [ukls_pkg::KEY_W-1:0] key,
                             input logic [ukls_pkg::DATA_W-1:0] data);
        int gap;
        gap = (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {data, key};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off until every outstanding transaction has its result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    initial begin
        ukls_pkg::t_op op;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pop, extreme pairs, duplicate, fill to full, full and duplicate-at-full
        send_item(ukls_pkg::OP_POP, $urandom(), $urandom());
        send_item(ukls_pkg::OP_PUSH, 32'h8000_0000, 32'h7fff_ffff);
        send_item(ukls_pkg::OP_PUSH, 32'h7fff_ffff, 32'h8000_0000);
        send_item(ukls_pkg::OP_PUSH, 32'h8000_0000, 32'h0000_0000);
        send_item(ukls_pkg::OP_POP, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            send_item(ukls_pkg::OP_PUSH, 32'(i), (i == 0) ? 32'hffff_ffff : $urandom());
        end
        send_item(ukls_pkg::OP_PUSH, 32'h1234_5678, $urandom());
        send_item(ukls_pkg::OP_PUSH, 32'h8000_0000, $urandom());
        send_item(ukls_pkg::OP_POP, $urandom(), $urandom());
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            calm <= (p % 5 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < push_pct[p % 5]) ? ukls_pkg::OP_PUSH
                                                               : ukls_pkg::OP_POP;
                send_item(op, pick_key(), $urandom());
            end
            if (p % 4 == 3) drain();
        end
        drain();

        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
